@@ hw/rtl/tsht_pkg.sv @@
// ----------------------------------------------------------------------------
// tsht_pkg: shared types and constants of the two-slot hash table
// Bucket sizing, the slot layout and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package tsht_pkg;

	// bucket count follows from the index width
	localparam int INDEX_BITS  = 10;
	localparam int NUM_BUCKETS = 1 << INDEX_BITS;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_STORE  = 1'b1;

	localparam logic [1:0] KIND_EMPTY = 2'd0;

	typedef logic [INDEX_BITS-1:0] bucket_idx_t;

	// one slot as stored: 122 bits
	typedef struct packed {
		logic [63:0]        key;
		logic [15:0]        move;
		logic signed [31:0] score;
		logic [1:0]         kind;
		logic [7:0]         depth;
	} slot_t;

	// controller to datapath
	typedef struct packed {
		logic        rd_en;
		logic        clear;
		bucket_idx_t clr_idx;
		logic        store_en;
		logic        out_load;
	} tsht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_lookup;
	} tsht_stat_t;

endpackage

@@ hw/rtl/tsht_if.sv @@
// ----------------------------------------------------------------------------
// tsht_if: request and response channels of the two-slot hash table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tsht_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [63:0]        key;
	logic [15:0]        best_move;
	logic signed [31:0] score;
	logic [1:0]         bound_kind;
	logic [7:0]         search_depth;

	modport source (output valid, opcode, key, best_move, score, bound_kind, search_depth,
		input ready);
	modport sink (input valid, opcode, key, best_move, score, bound_kind, search_depth,
		output ready);
endinterface

interface tsht_out_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [15:0]        found_move;
	logic signed [31:0] found_score;
	logic [1:0]         found_kind;
	logic [7:0]         found_depth;

	modport source (output valid, hit, found_move, found_score, found_kind, found_depth,
		input ready);
	modport sink (input valid, hit, found_move, found_score, found_kind, found_depth,
		output ready);
endinterface

@@ hw/rtl/tsht_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsht_ctrl: sequencing of the two-slot hash table
// Runs the clearing pass after reset, then reads a bucket for each accepted
// request and then commits the store or the lookup response.
// ----------------------------------------------------------------------------
module tsht_ctrl
	import tsht_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  tsht_stat_t stat,
	output tsht_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL
	} state_t;

	state_t      state_q;
	bucket_idx_t clr_idx_q;
	logic        out_valid_q;
	logic        accept;
	logic        stall;
	logic        commit;

	// request handshake and response back-pressure
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign stall    = stat.is_lookup && out_valid_q && !out_ready;
	assign commit   = (state_q == S_EVAL) && !stall;

	// commands to the datapath
	always_comb begin
		cmd.rd_en    = accept;
		cmd.clear    = (state_q == S_CLEAR);
		cmd.clr_idx  = clr_idx_q;
		cmd.store_en = commit && !stat.is_lookup;
		cmd.out_load = commit && stat.is_lookup;
	end

	assign out_valid = out_valid_q;

	// state, clear counter and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == bucket_idx_t'(NUM_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/tsht_dp.sv @@
// ----------------------------------------------------------------------------
// tsht_dp: slot memories and replacement datapath
// Holds both slot arrays, the request register, the registered bucket read,
// the depth-preferred replacement decision and the response register.
// ----------------------------------------------------------------------------
module tsht_dp
	import tsht_pkg::*;
(
	input  logic               clk,
	input  tsht_cmd_t          cmd,
	output tsht_stat_t         stat,
	input  logic               in_opcode,
	input  logic [63:0]        in_key,
	input  logic [15:0]        in_best_move,
	input  logic signed [31:0] in_score,
	input  logic [1:0]         in_bound_kind,
	input  logic [7:0]         in_search_depth,
	output logic               out_hit,
	output logic [15:0]        out_found_move,
	output logic signed [31:0] out_found_score,
	output logic [1:0]         out_found_kind,
	output logic [7:0]         out_found_depth
);

	slot_t first_mem  [NUM_BUCKETS];
	slot_t second_mem [NUM_BUCKETS];

	logic        op_q;
	slot_t       req_q;
	slot_t       first_rd_q;
	slot_t       second_rd_q;
	logic        hit_q;
	slot_t       found_q;

	logic        match_first;
	logic        match_second;
	logic        wr_first;
	logic        wr_second;
	logic        tie_move;
	bucket_idx_t wr_idx;
	slot_t       first_wdata;
	slot_t       second_wdata;

	assign stat.is_lookup = (op_q == OP_LOOKUP);

	// request capture and bucket read
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			op_q        <= in_opcode;
			req_q       <= '{key: in_key, move: in_best_move, score: in_score,
				kind: in_bound_kind, depth: in_search_depth};
			first_rd_q  <= first_mem[in_key[INDEX_BITS-1:0]];
			second_rd_q <= second_mem[in_key[INDEX_BITS-1:0]];
		end
	end

	// key compare, slot one first
	assign match_first  = (first_rd_q.key == req_q.key);
	assign match_second = (second_rd_q.key == req_q.key);

	// depth-preferred replacement choice
	always_comb begin
		wr_first  = 1'b0;
		wr_second = 1'b0;
		tie_move  = 1'b0;
		priority if (match_first) begin
			wr_first = (req_q.depth > first_rd_q.depth);
		end else if (match_second) begin
			wr_second = (req_q.depth > second_rd_q.depth);
		end else if (first_rd_q.kind == KIND_EMPTY) begin
			wr_first = 1'b1;
		end else if (second_rd_q.kind == KIND_EMPTY) begin
			wr_second = 1'b1;
		end else if (first_rd_q.depth < second_rd_q.depth) begin
			wr_first = 1'b1;
		end else if (second_rd_q.depth < first_rd_q.depth) begin
			wr_second = 1'b1;
		end else begin
			// equal depth: slot one moves down, new entry goes on top
			wr_first  = 1'b1;
			wr_second = 1'b1;
			tie_move  = 1'b1;
		end
	end

	// write port: clearing pass or store commit
	always_comb begin
		if (cmd.clear) begin
			wr_idx       = cmd.clr_idx;
			first_wdata  = '0;
			second_wdata = '0;
		end else begin
			wr_idx       = req_q.key[INDEX_BITS-1:0];
			first_wdata  = req_q;
			second_wdata = tie_move ? first_rd_q : req_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear || (cmd.store_en && wr_first)) begin
			first_mem[wr_idx] <= first_wdata;
		end
		if (cmd.clear || (cmd.store_en && wr_second)) begin
			second_mem[wr_idx] <= second_wdata;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			hit_q <= match_first || match_second;
			priority if (match_first) begin
				found_q <= first_rd_q;
			end else if (match_second) begin
				found_q <= second_rd_q;
			end else begin
				found_q <= '0;
			end
		end
	end

	assign out_hit         = hit_q;
	assign out_found_move  = found_q.move;
	assign out_found_score = found_q.score;
	assign out_found_kind  = found_q.kind;
	assign out_found_depth = found_q.depth;

endmodule

@@ hw/rtl/two_slot_hash_table_depth_replace_core.sv @@
// ----------------------------------------------------------------------------
// two_slot_hash_table_depth_replace_core: two-way depth-preferred hash table
//
//   channel   dir  beat carries
//   in_ch     in   opcode, key, best_move, score, bound_kind, search_depth
//   out_ch    out  hit, found_move, found_score, found_kind, found_depth
//
// Each request first reads the bucket from both slot memories into
// registers, then compares keys and writes back or loads the response
// register. A new request is taken only once the last one has committed.
// After reset a clearing pass zeroes one bucket a cycle over all NUM_BUCKETS
// buckets (1024 at ten index bits), with in_ch.ready low.
// A pending response does not block the next request; only a lookup that
// finds the response register still full waits for out_ch.ready.
// ----------------------------------------------------------------------------
module two_slot_hash_table_depth_replace_core
	import tsht_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tsht_in_if.sink    in_ch,
	tsht_out_if.source out_ch
);

	tsht_cmd_t  cmd;
	tsht_stat_t stat;

	// sequencing
	tsht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// memories and replacement logic
	tsht_dp u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.stat            (stat),
		.in_opcode       (in_ch.opcode),
		.in_key          (in_ch.key),
		.in_best_move    (in_ch.best_move),
		.in_score        (in_ch.score),
		.in_bound_kind   (in_ch.bound_kind),
		.in_search_depth (in_ch.search_depth),
		.out_hit         (out_ch.hit),
		.out_found_move  (out_ch.found_move),
		.out_found_score (out_ch.found_score),
		.out_found_kind  (out_ch.found_kind),
		.out_found_depth (out_ch.found_depth)
	);

endmodule

@@ tb/two_slot_hash_table_depth_replace_core_tb.sv @@
// ----------------------------------------------------------------------------
// two_slot_hash_table_depth_replace_core_tb: self-checking bench of the table
// Keeps its own copy of both slot arrays and works out every lookup answer
// as requests are taken. Directed beats cover the key-zero empty slot, the
// ignored equal-depth update, fill, shallower replace and the tie shift; then
// random traffic on a few crowded buckets, with random stalls on both
// channels, a long response hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_slot_hash_table_depth_replace_core_tb;
	import tsht_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int TAIL_CYCLES  = 20;
	localparam int NUM_TAGS     = 5;
	localparam int NUM_HOT      = 6;

	typedef struct packed {
		logic               opcode;
		logic [63:0]        key;
		logic [15:0]        move;
		logic signed [31:0] score;
		logic [1:0]         kind;
		logic [7:0]         depth;
	} probe_t;

	typedef struct packed {
		logic               hit;
		logic [15:0]        move;
		logic signed [31:0] score;
		logic [1:0]         kind;
		logic [7:0]         depth;
	} answer_t;

	logic clk;
	logic arst_n;

	tsht_in_if  in_ch();
	tsht_out_if out_ch();

	two_slot_hash_table_depth_replace_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// shadow copy of both ways
	slot_t way_one [NUM_BUCKETS];
	slot_t way_two [NUM_BUCKETS];

	answer_t     pending_answers[$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          quiet = 1'b0;
	int          hold_cycles = 0;
	logic [63:0] tag_pool [NUM_TAGS];
	bucket_idx_t hot_buckets [NUM_HOT];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// known input levels from time zero
	initial begin
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.opcode       = OP_LOOKUP;
		in_ch.key          = '0;
		in_ch.best_move    = '0;
		in_ch.score        = '0;
		in_ch.bound_kind   = KIND_EMPTY;
		in_ch.search_depth = '0;
		out_ch.ready       = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// shadow table access: updates the copy, returns 1 when a lookup answers
	function automatic bit table_access(input probe_t p, output answer_t ans);
		bucket_idx_t idx;
		slot_t       nw;
		idx = p.key[INDEX_BITS-1:0];
		ans = '0;
		if (p.opcode == OP_LOOKUP) begin
			if (way_one[idx].key == p.key) begin
				ans = {1'b1, way_one[idx].move, way_one[idx].score, way_one[idx].kind,
					way_one[idx].depth};
			end else if (way_two[idx].key == p.key) begin
				ans = {1'b1, way_two[idx].move, way_two[idx].score, way_two[idx].kind,
					way_two[idx].depth};
			end
			return 1'b1;
		end
		nw = '{key: p.key, move: p.move, score: p.score, kind: p.kind, depth: p.depth};
		if (way_one[idx].key == p.key) begin
			if (nw.depth > way_one[idx].depth) way_one[idx] = nw;
		end else if (way_two[idx].key == p.key) begin
			if (nw.depth > way_two[idx].depth) way_two[idx] = nw;
		end else if (way_one[idx].kind == KIND_EMPTY) begin
			way_one[idx] = nw;
		end else if (way_two[idx].kind == KIND_EMPTY) begin
			way_two[idx] = nw;
		end else if (way_one[idx].depth < way_two[idx].depth) begin
			way_one[idx] = nw;
		end else if (way_two[idx].depth < way_one[idx].depth) begin
			way_two[idx] = nw;
		end else begin
			// depth tie: slot one moves down
			way_two[idx] = way_one[idx];
			way_one[idx] = nw;
		end
		return 1'b0;
	endfunction

	// response check first, then predict the request taken at this edge
	always @(posedge clk) begin
		answer_t want;
		answer_t got;
		probe_t  p;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.hit, out_ch.found_move, out_ch.found_score, out_ch.found_kind,
					out_ch.found_depth};
				if (pending_answers.size() == 0) begin
					$display("%0t: unexpected response hit=%0d move=%h score=%0d kind=%0d depth=%0d",
						$time, got.hit, got.move, got.score, got.kind, got.depth);
					error_count++;
				end else begin
					want = pending_answers.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch exp hit=%0d move=%h score=%0d kind=%0d depth=%0d",
							$time, want.hit, want.move, want.score, want.kind, want.depth);
						$display("%0t:          act hit=%0d move=%h score=%0d kind=%0d depth=%0d",
							$time, got.hit, got.move, got.score, got.kind, got.depth);
						error_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				p = {in_ch.opcode, in_ch.key, in_ch.best_move, in_ch.score, in_ch.bound_kind,
					in_ch.search_depth};
				if (table_access(p, want)) pending_answers.push_back(want);
			end
		end
	end

	// response side: random stall bursts, long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles = hold_cycles - 1;
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 14) - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// one request beat, with an optional idle burst ahead of it
	task automatic send_beat(input probe_t p);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.opcode       <= p.opcode;
		in_ch.key          <= p.key;
		in_ch.best_move    <= p.move;
		in_ch.score        <= p.score;
		in_ch.bound_kind   <= p.kind;
		in_ch.search_depth <= p.depth;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic put(input logic op, input logic [63:0] key, input logic [15:0] move,
		input logic signed [31:0] score, input logic [1:0] kind, input logic [7:0] depth);
		send_beat('{opcode: op, key: key, move: move, score: score, kind: kind, depth: depth});
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0) @(posedge clk);
	endtask

	// fresh tags and crowded buckets for the random traffic
	task automatic refill_pools();
		for (int i = 0; i < NUM_TAGS; i++) tag_pool[i] = {$urandom, $urandom};
		for (int i = 0; i < NUM_HOT; i++)
			hot_buckets[i] = bucket_idx_t'($urandom_range(0, NUM_BUCKETS - 1));
	endtask

	function automatic probe_t random_probe(input bit lookups_only);
		probe_t p;
		int     pick;
		p.opcode = lookups_only ? OP_LOOKUP : logic'($urandom_range(0, 1));
		pick = $urandom_range(0, 19);
		if (pick == 0) p.key = '0;
		else if (pick == 1) p.key = {$urandom, $urandom};
		else p.key = {tag_pool[$urandom_range(0, NUM_TAGS - 1)][63:INDEX_BITS],
			hot_buckets[$urandom_range(0, NUM_HOT - 1)]};
		p.move  = 16'($urandom);
		p.score = $urandom;
		p.kind  = ($urandom_range(0, 6) == 0) ? KIND_EMPTY : 2'($urandom_range(1, 3));
		// mostly shallow depths so ties and equal-depth updates come up often
		p.depth = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
		return p;
	endfunction

	task automatic do_reset();
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			way_one[i] = '0;
			way_two[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// hand-picked beats through the replacement rules, all but a shallower slot one
	task automatic test_directed();
		logic [63:0] ka, kb, kc, kd, ke;
		ka = 64'hFFFF_FFFF_FFFF_FFFF;
		kb = 64'h7FFF_FFFF_FFFF_FFFF;
		kc = 64'h0000_0000_0000_03FF;
		kd = 64'h8000_0000_0000_0001;
		ke = 64'h4000_0000_0000_0001;
		// empty slot carries key zero
		put(OP_LOOKUP, '0, '0, '0, KIND_EMPTY, '0);
		put(OP_STORE, '0, 16'h1234, 32'sd77, 2'd2, 8'd0);
		put(OP_LOOKUP, '0, '0, '0, KIND_EMPTY, '0);
		put(OP_STORE, '0, 16'hFFFF, 32'h8000_0000, 2'd3, 8'd5);
		put(OP_LOOKUP, '0, '0, '0, KIND_EMPTY, '0);
		// fill, equal-depth ignore, shallower replace, tie shift
		put(OP_LOOKUP, ka, '0, '0, KIND_EMPTY, '0);
		put(OP_STORE, ka, 16'h0000, 32'h7FFF_FFFF, 2'd1, 8'd255);
		put(OP_STORE, kb, 16'hA5A5, -32'sd1, 2'd2, 8'd10);
		put(OP_STORE, ka, 16'h5A5A, 32'sd3, 2'd3, 8'd255);
		put(OP_LOOKUP, ka, 16'hFFFF, -32'sd1, 2'd3, 8'd255);
		put(OP_STORE, kc, 16'h0001, 32'sd1, 2'd1, 8'd3);
		put(OP_LOOKUP, kb, '0, '0, KIND_EMPTY, '0);
		put(OP_LOOKUP, kc, '0, '0, KIND_EMPTY, '0);
		put(OP_STORE, kc, 16'h0002, 32'sd2, 2'd2, 8'd200);
		put(OP_STORE, kb, 16'h0003, 32'sd4, 2'd3, 8'd255);
		put(OP_STORE, kc, 16'h0004, -32'sd9, 2'd1, 8'd7);
		put(OP_LOOKUP, ka, '0, '0, KIND_EMPTY, '0);
		put(OP_LOOKUP, kc, '0, '0, KIND_EMPTY, '0);
		put(OP_LOOKUP, kb, '0, '0, KIND_EMPTY, '0);
		// kind zero entry still counts as empty
		put(OP_STORE, kd, 16'hBEEF, 32'sd100, KIND_EMPTY, 8'd9);
		put(OP_LOOKUP, kd, '0, '0, KIND_EMPTY, '0);
		put(OP_STORE, ke, 16'hCAFE, 32'sd200, 2'd1, 8'd2);
		put(OP_LOOKUP, kd, '0, '0, KIND_EMPTY, '0);
		put(OP_LOOKUP, ke, '0, '0, KIND_EMPTY, '0);
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) send_beat(random_probe(1'b0));
	endtask

	// response side held off while requests keep coming
	task automatic test_response_hold();
		hold_cycles = 400;
		for (int i = 0; i < 80; i++) send_beat(random_probe(1'b1));
	endtask

	// request side waits for every answer before going on
	task automatic test_drain_pause();
		for (int i = 0; i < 40; i++) send_beat(random_probe(1'b0));
		wait_drained();
		for (int i = 0; i < 40; i++) send_beat(random_probe(1'b0));
	endtask

	task automatic test_back_to_back(input int count);
		quiet = 1'b1;
		for (int i = 0; i < count; i++) send_beat(random_probe(1'b0));
	endtask

	initial begin
		do_reset();
		refill_pools();
		test_directed();
		test_random_traffic(800);
		test_response_hold();
		test_drain_pause();
		refill_pools();
		test_random_traffic(560);
		test_back_to_back(320);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
